### rtl/core/dual_lcg_shuffle_rng_top_defines.svh
// Assertion macros shared by the RNG core modules.
`ifndef DUAL_LCG_SHUFFLE_RNG_TOP_DEFINES_SVH
`define DUAL_LCG_SHUFFLE_RNG_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define DLSR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define DLSR_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DLSR_ASSERT(label, clk, rst, prop)
`define DLSR_ASSERT_NORST(label, clk, prop)
`endif

`endif

### rtl/core/dlsr_pkg.sv
package dlsr_pkg;

   localparam int TABLE_DEPTH    = 256;
   localparam int ADDR_W         = $clog2(TABLE_DEPTH);
   localparam int WORD_W         = 32;
   localparam int TIME_W         = 64;
   localparam int CMD_W          = 2;
   localparam int SET_W          = 3;
   localparam int FILL_STRIDE    = 100;
   localparam int FILL_CNT_W     = $clog2(FILL_STRIDE);
   localparam int WARMUP_STEPS   = 3761;
   localparam int STEP_W         = $clog2(WARMUP_STEPS);
   localparam int RESEED_PERIOD  = 100;
   localparam int RESEED_W       = $clog2(RESEED_PERIOD);
   localparam int FRACTION_STEPS = 7;
   localparam int FRAC_W         = $clog2(FRACTION_STEPS);

   localparam logic [SET_W-1:0]  SET_MAX      = 3'd4;
   localparam logic [WORD_W-1:0] SEED_X_RESET = 32'h3876_2CA5;
   localparam logic [WORD_W-1:0] SEED_Y_RESET = 32'h7B2C_D169;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT = 2'd0,
      CMD_WORD = 2'd1,
      CMD_FRAC = 2'd2
   } cmd_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_FILL,
      ST_WARM,
      ST_DRAW,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              take;
      logic              seed_load;
      logic              lcg_step;
      logic              fill_wr;
      logic [ADDR_W-1:0] fill_addr;
      logic              shuf_step;
      logic              rsp_load;
      logic              rsp_zero;
   } dlsr_cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0] ax;
      logic [WORD_W-1:0] bx;
      logic [WORD_W-1:0] ay;
      logic [WORD_W-1:0] by;
   } coef_type;

   function automatic coef_type coef_lookup(input logic [SET_W-1:0] set);
      coef_type c;
      case (set)
         3'd0:    c = '{32'h007D_6795, 32'h547F_289B, 32'h009B_2979, 32'hCD54_8A23};
         3'd1:    c = '{32'h009A_3717, 32'h5FA4_7831, 32'h007D_4517, 32'h1F37_9355};
         3'd2:    c = '{32'h007B_21F3, 32'hB219_D459, 32'h008A_673F, 32'h768A_B1E7};
         3'd3:    c = '{32'h009A_3257, 32'h369D_E46B, 32'h0097_326B, 32'h651F_446F};
         default: c = '{32'h0070_3F2B, 32'hD938_2B17, 32'h007A_2589, 32'hA769_1573};
      endcase
      return c;
   endfunction

endpackage

### rtl/core/dlsr_req_if.sv
interface dlsr_req_if;
   logic                           valid;
   logic                           ready;
   logic [dlsr_pkg::CMD_W-1:0]     command;
   logic [dlsr_pkg::SET_W-1:0]     coef_set;
   logic [dlsr_pkg::TIME_W-1:0]    time_value;

   modport source (output valid, output command, output coef_set, output time_value,
                   input ready);
   modport sink   (input valid, input command, input coef_set, input time_value,
                   output ready);
endinterface

### rtl/core/dlsr_rsp_if.sv
interface dlsr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dlsr_pkg::WORD_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

### rtl/core/dual_lcg_shuffle_rng_top.sv
// Shuffled dual-LCG random word generator.
// req_if carries command, coef_set and time_value; rsp_if returns one 32-bit
// word per accepted request. Both use valid/ready; a word moves when both are high.
// Commands: init (result 0), draw one word, draw fraction (seventh step's word);
// the spare code returns 0 too. Each generator step does two 32x32 multiplies
// into the x/y registers; the table read-modify-write of that step follows in the
// following cycle on the single 256-word table port, overlapped with the next step.
// An init runs seed, fill (one table word per 100 LCG steps), 3761 warm-up
// shuffle steps, then drain and finish; a draw runs its steps, drain and finish.
// A new request is accepted in the cycle after the result is loaded, so the core
// takes no new request while one is still in progress.
// The result register holds the finished word; if rsp_if.ready is low the core
// still returns to idle and takes the next request, and waits only when a
// second result would overwrite an unread one.
// Reset zeroes the generators and coefficient set and reloads the fixed seeds;
// the table holds garbage until the first init. Draws before init return undefined words.
module dual_lcg_shuffle_rng_top (
   input  logic               clock,
   input  logic               reset,
   dlsr_req_if.sink           req_if,
   dlsr_rsp_if.source         rsp_if
);
   import dlsr_pkg::*;

   dlsr_cmd_type        cmd;
   logic [WORD_W-1:0]   rsp_value;

   dlsr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_command (req_if.command),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .cmd         (cmd)
   );

   dlsr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_coef_set   (req_if.coef_set),
      .req_time_value (req_if.time_value),
      .rsp_value      (rsp_value)
   );

   assign rsp_if.value = rsp_value;

endmodule

### rtl/core/dlsr_datapath.sv
`include "dual_lcg_shuffle_rng_top_defines.svh"

module dlsr_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  dlsr_pkg::dlsr_cmd_type        cmd,
   input  logic [dlsr_pkg::SET_W-1:0]    req_coef_set,
   input  logic [dlsr_pkg::TIME_W-1:0]   req_time_value,
   output logic [dlsr_pkg::WORD_W-1:0]   rsp_value
);
   import dlsr_pkg::*;

   localparam logic [RESEED_W-1:0] RESEED_LAST = RESEED_W'(RESEED_PERIOD - 1);

   logic [SET_W-1:0]    coef_ff;
   logic [TIME_W-1:0]   time_ff;
   logic [WORD_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [WORD_W-1:0]   seed_x_ff, seed_x_in, seed_y_ff, seed_y_in;
   logic [SET_W-1:0]    set_ff, set_in;
   logic [RESEED_W-1:0] rc_ff, rc_in;
   logic                wr_en_ff, wr_en_in;
   logic [ADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [WORD_W-1:0]   rd_ff;
   logic [WORD_W-1:0]   rsp_value_ff;
   logic [WORD_W-1:0]   mem [TABLE_DEPTH];

   coef_type            coefs;
   logic                reseed;
   logic [WORD_W-1:0]   t_lo, t_hi, xs, ys, nx, ny;

   always_comb begin
      coefs  = coef_lookup(set_ff);
      t_lo   = time_ff[WORD_W-1:0];
      t_hi   = time_ff[TIME_W-1:WORD_W];
      reseed = cmd.shuf_step && (rc_ff == RESEED_LAST);
      xs     = reseed ? (x_ff ^ t_lo) : x_ff;
      ys     = reseed ? (y_ff ^ t_hi) : y_ff;
      nx     = WORD_W'(coefs.ax * xs) + coefs.bx;
      ny     = WORD_W'(coefs.ay * ys) + coefs.by;
   end

   always_comb begin
      seed_x_in = seed_x_ff;
      seed_y_in = seed_y_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      set_in    = set_ff;
      rc_in     = rc_ff;
      if (cmd.seed_load) begin
         seed_x_in = seed_x_ff ^ t_lo;
         seed_y_in = seed_y_ff ^ t_hi;
         x_in      = seed_x_ff ^ t_lo;
         y_in      = seed_y_ff ^ t_hi;
         set_in    = (coef_ff > SET_MAX) ? SET_MAX : coef_ff;
         rc_in     = '0;
      end else if (cmd.lcg_step || cmd.shuf_step) begin
         x_in = nx;
         y_in = ny;
         if (cmd.shuf_step) begin
            rc_in = reseed ? '0 : rc_ff + 1'b1;
         end
      end
      wr_en_in   = cmd.fill_wr || cmd.shuf_step;
      wr_addr_in = cmd.fill_wr ? cmd.fill_addr : ny[WORD_W-1 -: ADDR_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff      <= '0;
         y_ff      <= '0;
         seed_x_ff <= SEED_X_RESET;
         seed_y_ff <= SEED_Y_RESET;
         set_ff    <= '0;
         rc_ff     <= '0;
         wr_en_ff  <= 1'b0;
      end else begin
         x_ff      <= x_in;
         y_ff      <= y_in;
         seed_x_ff <= seed_x_in;
         seed_y_ff <= seed_y_in;
         set_ff    <= set_in;
         rc_ff     <= rc_in;
         wr_en_ff  <= wr_en_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      if (cmd.take) begin
         coef_ff <= req_coef_set;
         time_ff <= req_time_value;
      end
      if (cmd.rsp_load) begin
         rsp_value_ff <= cmd.rsp_zero ? '0 : rd_ff;
      end
   end

   // read-first table port: old word out, new x in
   always_ff @(posedge clock) begin
      if (wr_en_ff) begin
         rd_ff            <= mem[wr_addr_ff];
         mem[wr_addr_ff]  <= x_ff;
      end
   end

   assign rsp_value = rsp_value_ff;

   `DLSR_ASSERT(a_rc_range, clock, reset, rc_ff <= RESEED_LAST)
   `DLSR_ASSERT(a_set_range, clock, reset, set_ff <= SET_MAX)
   `DLSR_ASSERT(a_seed_copy, clock, reset, cmd.seed_load |=> (x_ff == seed_x_ff && y_ff == seed_y_ff))

endmodule

### rtl/core/dlsr_ctrl.sv
`include "dual_lcg_shuffle_rng_top_defines.svh"

module dlsr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dlsr_pkg::CMD_W-1:0]  req_command,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output dlsr_pkg::dlsr_cmd_type      cmd
);
   import dlsr_pkg::*;

   localparam logic [FILL_CNT_W-1:0] INNER_LAST = FILL_CNT_W'(FILL_STRIDE - 1);
   localparam logic [ADDR_W-1:0]     ROW_LAST   = ADDR_W'(TABLE_DEPTH - 1);
   localparam logic [STEP_W-1:0]     WARM_LAST  = STEP_W'(WARMUP_STEPS - 1);
   localparam logic [FRAC_W-1:0]     FRAC_LAST  = FRAC_W'(FRACTION_STEPS - 1);

   state_type               state_ff, state_in;
   logic [FILL_CNT_W-1:0]   inner_ff, inner_in;
   logic [ADDR_W-1:0]       row_ff, row_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [FRAC_W-1:0]       last_ff, last_in;
   logic                    zero_ff, zero_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    accept, can_load;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign can_load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd_code_type'(req_command))
                  CMD_INIT:           state_in = ST_SEED;
                  CMD_WORD, CMD_FRAC: state_in = ST_DRAW;
                  default:            state_in = ST_FINISH;
               endcase
            end
         end
         ST_SEED:  state_in = ST_FILL;
         ST_FILL: begin
            if (inner_ff == INNER_LAST && row_ff == ROW_LAST) state_in = ST_WARM;
         end
         ST_WARM: begin
            if (step_ff == WARM_LAST) state_in = ST_DRAIN;
         end
         ST_DRAW: begin
            if (step_ff == STEP_W'(last_ff)) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_FINISH;
         ST_FINISH: begin
            if (can_load) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      inner_in = inner_ff;
      row_in   = row_ff;
      step_in  = step_ff;
      last_in  = last_ff;
      zero_in  = zero_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               last_in = (cmd_code_type'(req_command) == CMD_FRAC) ? FRAC_LAST : '0;
               zero_in = !(cmd_code_type'(req_command) == CMD_WORD ||
                           cmd_code_type'(req_command) == CMD_FRAC);
            end
         end
         ST_SEED: begin
            inner_in = '0;
            row_in   = '0;
            step_in  = '0;
         end
         ST_FILL: begin
            if (inner_ff == INNER_LAST) begin
               inner_in = '0;
               row_in   = row_ff + 1'b1;
            end else begin
               inner_in = inner_ff + 1'b1;
            end
         end
         ST_WARM, ST_DRAW: step_in = step_ff + 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd           = '0;
      cmd.take      = accept;
      cmd.seed_load = (state_ff == ST_SEED);
      cmd.lcg_step  = (state_ff == ST_FILL);
      cmd.fill_wr   = (state_ff == ST_FILL) && (inner_ff == INNER_LAST);
      cmd.fill_addr = row_ff;
      cmd.shuf_step = (state_ff == ST_WARM) || (state_ff == ST_DRAW);
      cmd.rsp_load  = (state_ff == ST_FINISH) && can_load;
      cmd.rsp_zero  = zero_ff;
      rsp_valid_in  = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inner_ff     <= '0;
         row_ff       <= '0;
         step_ff      <= '0;
         last_ff      <= '0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inner_ff     <= inner_in;
         row_ff       <= row_in;
         step_ff      <= step_in;
         last_ff      <= last_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `DLSR_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
   `DLSR_ASSERT(a_draw_bound, clock, reset, (state_ff == ST_DRAW) |-> (step_ff <= STEP_W'(FRAC_LAST)))
   `DLSR_ASSERT_NORST(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff))

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
   import dlsr_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int DIRECTED_ROWS = 20;
   localparam int RANDOM_WORDS  = 1330;
   localparam int MAX_RAND_INIT = 10;
   localparam logic [TIME_W-1:0] TIME_ONES = '1;

   typedef struct packed {
      logic [CMD_W-1:0]  op;
      logic [SET_W-1:0]  set;
      logic [TIME_W-1:0] stamp;
      logic              fixed;
      logic [WORD_W-1:0] word;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dlsr_req_if req_if();
   dlsr_rsp_if rsp_if();

   dual_lcg_shuffle_rng_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // generator coefficients, one entry per set
   logic [WORD_W-1:0] mul_x [5] = '{32'h007D6795, 32'h009A3717, 32'h007B21F3, 32'h009A3257,
                                    32'h00703F2B};
   logic [WORD_W-1:0] add_x [5] = '{32'h547F289B, 32'h5FA47831, 32'hB219D459, 32'h369DE46B,
                                    32'hD9382B17};
   logic [WORD_W-1:0] mul_y [5] = '{32'h009B2979, 32'h007D4517, 32'h008A673F, 32'h0097326B,
                                    32'h007A2589};
   logic [WORD_W-1:0] add_y [5] = '{32'hCD548A23, 32'h1F379355, 32'h768AB1E7, 32'h651F446F,
                                    32'hA7691573};

   logic [WORD_W-1:0] gen_x, gen_y, seed_lo, seed_hi;
   logic [SET_W-1:0]  coef_sel;
   int unsigned       reseed_cnt;
   logic [WORD_W-1:0] shuffle_mem [TABLE_DEPTH];

   logic [WORD_W-1:0] expected_words [$];
   int unsigned       fail_count = 0;
   int unsigned       sender_idle_pct = 0;
   int unsigned       stall_pct = 0;
   stim_row_type      directed_rows [DIRECTED_ROWS];

   function automatic logic [WORD_W-1:0] rng_advance(logic [TIME_W-1:0] stamp);
      logic [WORD_W-1:0] nx, ny, word;
      logic [ADDR_W-1:0] slot;
      reseed_cnt++;
      if (reseed_cnt >= RESEED_PERIOD) begin
         reseed_cnt = 0;
         gen_x ^= stamp[31:0];
         gen_y ^= stamp[63:32];
      end
      nx = mul_x[coef_sel] * gen_x + add_x[coef_sel];
      ny = mul_y[coef_sel] * gen_y + add_y[coef_sel];
      slot = ny[31:24];
      word = shuffle_mem[slot];
      shuffle_mem[slot] = nx;
      gen_x = nx;
      gen_y = ny;
      return word;
   endfunction

   function automatic void rng_initialize(logic [SET_W-1:0] set, logic [TIME_W-1:0] stamp);
      logic [WORD_W-1:0] unused;
      seed_lo ^= stamp[31:0];
      seed_hi ^= stamp[63:32];
      gen_x = seed_lo;
      gen_y = seed_hi;
      coef_sel = (set > SET_MAX) ? SET_MAX : set;
      for (int j = 0; j < TABLE_DEPTH; j++) begin
         for (int k = 0; k < FILL_STRIDE; k++) begin
            gen_x = mul_x[coef_sel] * gen_x + add_x[coef_sel];
            gen_y = mul_y[coef_sel] * gen_y + add_y[coef_sel];
         end
         shuffle_mem[j] = gen_x;
      end
      reseed_cnt = 0;
      for (int j = 0; j < WARMUP_STEPS; j++)
         unused = rng_advance(stamp);
   endfunction

   function automatic logic [WORD_W-1:0] rng_predict(logic [CMD_W-1:0] op,
                                                     logic [SET_W-1:0] set,
                                                     logic [TIME_W-1:0] stamp);
      logic [WORD_W-1:0] word;
      word = '0;
      case (op)
         CMD_INIT: rng_initialize(set, stamp);
         CMD_WORD: word = rng_advance(stamp);
         CMD_FRAC: begin
            for (int n = 0; n < FRACTION_STEPS; n++)
               word = rng_advance(stamp);
         end
         default: word = '0;
      endcase
      return word;
   endfunction

   task automatic send_word(logic [CMD_W-1:0] op, logic [SET_W-1:0] set,
                            logic [TIME_W-1:0] stamp, logic fixed, logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] predicted;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.command    <= op;
      req_if.coef_set   <= set;
      req_if.time_value <= stamp;
      do @(posedge clock); while (!req_if.ready);
      predicted = rng_predict(op, set, stamp);
      expected_words.push_back(fixed ? word : predicted);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic send_random(inout int unsigned inits);
      logic [CMD_W-1:0]  op;
      logic [TIME_W-1:0] stamp;
      int unsigned       pick, tsel;
      pick = $urandom_range(999);
      tsel = $urandom_range(15);
      stamp = (tsel == 0) ? '0 : (tsel == 1) ? TIME_ONES : {$urandom, $urandom};
      if (pick < 8 && inits < MAX_RAND_INIT) begin
         op = CMD_INIT;
         inits++;
      end else if (pick < 18) begin
         op = CMD_SPARE;
      end else if (pick < 560) begin
         op = CMD_WORD;
      end else begin
         op = CMD_FRAC;
      end
      send_word(op, SET_W'($urandom_range(7)), stamp, 1'b0, '0);
   endtask

   always @(negedge clock)
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_words.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected word %h at %0t", rsp_if.value, $time);
         end else begin
            logic [WORD_W-1:0] want;
            want = expected_words.pop_front();
            if (rsp_if.value !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("value mismatch at %0t: expected %h, got %h", $time, want,
                           rsp_if.value);
            end
         end
      end
   end

   initial begin
      #(80_000_000);
      $display("dual_lcg_shuffle_rng_top test failed");
      $finish;
   end

   initial begin
      int unsigned inits;
      inits = 0;
      req_if.valid      = 1'b0;
      req_if.command    = CMD_INIT;
      req_if.coef_set   = '0;
      req_if.time_value = '0;
      rsp_if.ready      = 1'b0;

      gen_x = '0;
      gen_y = '0;
      seed_lo = SEED_X_RESET;
      seed_hi = SEED_Y_RESET;
      coef_sel = '0;
      reseed_cnt = 0;
      foreach (shuffle_mem[i]) shuffle_mem[i] = '0;

      // inits return zero, as does the spare command
      directed_rows = '{
         '{CMD_INIT,  3'd0, 64'h0,                 1'b1, 32'h0},
         '{CMD_WORD,  3'd0, 64'h0,                 1'b0, 32'h0},
         '{CMD_WORD,  3'd7, TIME_ONES,             1'b0, 32'h0},
         '{CMD_FRAC,  3'd0, 64'h0,                 1'b0, 32'h0},
         '{CMD_SPARE, 3'd7, TIME_ONES,             1'b1, 32'h0},
         '{CMD_WORD,  3'd0, 64'h0,                 1'b0, 32'h0},
         '{CMD_INIT,  3'd7, TIME_ONES,             1'b1, 32'h0},
         '{CMD_FRAC,  3'd0, TIME_ONES,             1'b0, 32'h0},
         '{CMD_WORD,  3'd2, 64'hDEADBEEF_01234567, 1'b0, 32'h0},
         '{CMD_INIT,  3'd5, 64'h01234567_89ABCDEF, 1'b1, 32'h0},
         '{CMD_WORD,  3'd0, 64'h0,                 1'b0, 32'h0},
         '{CMD_FRAC,  3'd0, 64'hFFFFFFFF_00000000, 1'b0, 32'h0},
         '{CMD_INIT,  3'd1, 64'h80000000_00000001, 1'b1, 32'h0},
         '{CMD_WORD,  3'd0, 64'h00000000_FFFFFFFF, 1'b0, 32'h0},
         '{CMD_INIT,  3'd2, 64'h5A5A5A5A_A5A5A5A5, 1'b1, 32'h0},
         '{CMD_FRAC,  3'd0, 64'h0,                 1'b0, 32'h0},
         '{CMD_INIT,  3'd3, 64'h0,                 1'b1, 32'h0},
         '{CMD_WORD,  3'd0, TIME_ONES,             1'b0, 32'h0},
         '{CMD_SPARE, 3'd0, 64'h0,                 1'b1, 32'h0},
         '{CMD_FRAC,  3'd4, TIME_ONES,             1'b0, 32'h0}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].op, directed_rows[i].set, directed_rows[i].stamp,
                   directed_rows[i].fixed, directed_rows[i].word);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 46; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 46; end
            default: begin sender_idle_pct = 20; stall_pct = 20; end
         endcase
         for (int n = 0; n < RANDOM_WORDS / 4; n++)
            send_random(inits);
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("dual_lcg_shuffle_rng_top test passed");
      end else begin
         $display("dual_lcg_shuffle_rng_top test failed");
      end
      $finish;
   end

endmodule
